/* rtl/cgsa_pkg.sv */
// ----------------------------------------------------------------------------
// cgsa_pkg
// Shared types, constants and the control store of the charge gauge sweep
// animator.
// ----------------------------------------------------------------------------
`default_nettype none

package cgsa_pkg;

   localparam int TIME_W   = 32;
   localparam int DT_W     = 16;
   localparam int PCT_W    = 7;
   localparam int ANG_W    = 17;
   localparam int REG_W    = 16;
   localparam int SWP_W    = 9;
   localparam int PROD_W   = ANG_W + DT_W;
   localparam int DVD_W    = 40;
   localparam int QUO_W    = ANG_W;
   localparam int CNT_W    = $clog2(QUO_W + 1);
   localparam int PC_W     = 4;
   localparam int ADDR_W   = 2;
   localparam int SCL_W    = 24;
   localparam int RCP_W    = 25;
   localparam int RCP_SH   = 31;

   localparam logic [REG_W-1:0]  EASE_RESET  = 16'd160;
   localparam logic [REG_W-1:0]  SPEED_RESET = 16'd900;
   localparam logic [SWP_W-1:0]  SWEEP_RESET = 9'd300;
   localparam logic [SWP_W-1:0]  SWEEP_MAX   = 9'd300;
   localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
   localparam logic [DT_W-1:0]   DT_FIRST    = 16'd16;
   localparam logic [ANG_W-1:0]  SNAP_LIM    = 17'd77;   // 10*d < 768
   localparam logic [ANG_W-1:0]  ANG_MAX     = 17'd76800;

   // reciprocals, ceil(2^31/100) and ceil(2^31/125); exact over the operand range
   localparam logic [RCP_W-1:0]  RCP_PCT     = 25'd21474837;
   localparam logic [RCP_W-1:0]  RCP_CAP     = 25'd17179870;
   // speed*dt from here on gives a cap above any angle distance
   localparam logic [PROD_W-1:0] CAP_SAT     = 33'd512000;

   // csr indexes
   localparam logic [ADDR_W-1:0] CSR_EASE  = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_SPEED = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_SWEEP = 2'd2;

   // operand / destination selects of a micro-op
   localparam logic [1:0] SEL_ARC_TGT = 2'd0;
   localparam logic [1:0] SEL_CAP     = 2'd1;
   localparam logic [1:0] SEL_TRK     = 2'd2;
   localparam logic [1:0] SEL_ARC     = 2'd3;

   typedef enum logic [2:0] {
      OP_WAIT_REQ,
      OP_MUL,
      OP_SCALE,
      OP_DIV_GO,
      OP_DIV_WAIT,
      OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [1:0]      sel;
      logic [PC_W-1:0] nxt;
   } cw_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [ANG_W-1:0] divisor;
   } div_req_type;

   localparam logic [PC_W-1:0] PC_LAST = 4'd11;

   function automatic cw_type microcode(input logic [PC_W-1:0] pc);
      cw_type cw;
      cw = '{op: OP_WAIT_REQ, sel: SEL_ARC_TGT, nxt: 4'd1};
      unique case (pc)
         4'd0:    cw = '{op: OP_WAIT_REQ, sel: SEL_ARC_TGT, nxt: 4'd1};
         4'd1:    cw = '{op: OP_MUL,      sel: SEL_ARC_TGT, nxt: 4'd2};
         4'd2:    cw = '{op: OP_SCALE,    sel: SEL_ARC_TGT, nxt: 4'd3};
         4'd3:    cw = '{op: OP_MUL,      sel: SEL_CAP,     nxt: 4'd4};
         4'd4:    cw = '{op: OP_SCALE,    sel: SEL_CAP,     nxt: 4'd5};
         4'd5:    cw = '{op: OP_MUL,      sel: SEL_TRK,     nxt: 4'd6};
         4'd6:    cw = '{op: OP_DIV_GO,   sel: SEL_TRK,     nxt: 4'd7};
         4'd7:    cw = '{op: OP_DIV_WAIT, sel: SEL_TRK,     nxt: 4'd8};
         4'd8:    cw = '{op: OP_MUL,      sel: SEL_ARC,     nxt: 4'd9};
         4'd9:    cw = '{op: OP_DIV_GO,   sel: SEL_ARC,     nxt: 4'd10};
         4'd10:   cw = '{op: OP_DIV_WAIT, sel: SEL_ARC,     nxt: 4'd11};
         4'd11:   cw = '{op: OP_COMMIT,   sel: SEL_ARC_TGT, nxt: 4'd0};
         default: cw = '{op: OP_WAIT_REQ, sel: SEL_ARC_TGT, nxt: 4'd0};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

/* rtl/cgsa_div.sv */
// ----------------------------------------------------------------------------
// cgsa_div
// Restoring divider, one quotient bit per cycle, quotient saturated to its
// width when it would not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module cgsa_div
   import cgsa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire div_req_type      div_req,
   output logic                  busy,
   output logic [QUO_W-1:0]      quotient
);

   logic [ANG_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [ANG_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [ANG_W:0]   shifted;
   logic             fits;
   logic             ovf;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};
   assign ovf     = div_req.dividend >=
                    {{(DVD_W-ANG_W-QUO_W){1'b0}}, div_req.divisor, {QUO_W{1'b0}}};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_req.start) begin
         dsr_in = div_req.divisor;
         cnt_in = CNT_W'(QUO_W);
         if (ovf) begin
            quo_in  = '1;
            busy_in = 1'b0;
         end else begin
            // upper part is below the divisor here
            rem_in  = div_req.dividend[ANG_W+QUO_W-1:QUO_W];
            quo_in  = div_req.dividend[QUO_W-1:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? ANG_W'(shifted - {1'b0, dsr_ff}) : shifted[ANG_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/charge_gauge_sweep_animator_top.sv */
// ----------------------------------------------------------------------------
// charge_gauge_sweep_animator_top
// Eases a gauge track and charge arc toward their targets once per frame tick.
// ----------------------------------------------------------------------------
// One request is taken, then a 12-step control program runs a shared
// multiplier, a reciprocal multiplication for the arc target and the speed cap,
// and a one-bit-per-cycle divider for the track and arc steps. The two serial
// divisions set most of the time from acceptance to the result being
// registered. The next request can be taken the cycle after the result is
// loaded, while the result may still wait on rsp_tready; a result still
// waiting when the next one is ready holds the program in its last step.
// The first tick after reset uses a 16 ms frame time.
`default_nettype none

module charge_gauge_sweep_animator_top
   import cgsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [39:0]       req_tdata,   // time_ms, charger_on, percent
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // track_angle, arc_angle, gauge_shown, track_moved, arc_moved, zero pad
   output logic [39:0]            rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [ADDR_W-1:0] csr_addr,
   input  wire logic [REG_W-1:0]  csr_wdata
);

   function automatic logic [ANG_W-1:0] move_toward(
      input logic [ANG_W-1:0] cur,
      input logic [ANG_W-1:0] tgt,
      input logic [ANG_W-1:0] raw_step,
      input logic [ANG_W-1:0] cap
   );
      logic             up;
      logic [ANG_W-1:0] d;
      logic [ANG_W-1:0] stp;
      up  = tgt >= cur;
      d   = up ? ANG_W'(tgt - cur) : ANG_W'(cur - tgt);
      stp = (raw_step > cap) ? cap : raw_step;
      if (d < SNAP_LIM || stp >= d) begin
         return tgt;
      end
      return up ? ANG_W'(cur + stp) : ANG_W'(cur - stp);
   endfunction

   // csr
   logic [REG_W-1:0]  ease_ff, speed_ff;
   logic [SWP_W-1:0]  sweep_deg_ff;

   // sequencer and datapath
   logic [PC_W-1:0]   pc_ff, pc_in;
   cw_type            cw;
   logic              adv;
   logic [TIME_W-1:0] last_time_ff;
   logic              seen_ff;
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic              on_ff;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic [PROD_W-1:0] prod_ff;
   logic [ANG_W-1:0]  arc_tgt_ff, cap_ff, stp_trk_ff, stp_arc_ff;
   logic [ANG_W-1:0]  track_ff, arc_ff;
   logic [ANG_W-1:0]  track_new, arc_new;

   logic              rsp_valid_ff;
   logic [39:0]       rsp_data_ff;

   logic [SWP_W-1:0]  sweep_deg;
   logic [ANG_W-1:0]  sweep;
   logic [DT_W-1:0]   tau;
   logic [ANG_W-1:0]  dt_tau;
   logic [TIME_W-1:0] elapsed;
   logic              accept;
   logic              commit;
   logic [ANG_W-1:0]  track_aim, arc_aim, d_trk, d_arc;
   logic [ANG_W-1:0]  mul_a;
   logic [DT_W-1:0]   mul_b;
   logic [SCL_W-1:0]  scl_a;
   logic [RCP_W-1:0]  scl_m;
   logic [SCL_W+RCP_W-1:0] scl_prod;
   logic [ANG_W-1:0]  scl_q;
   div_req_type       div_req;
   logic              div_busy;
   logic [QUO_W-1:0]  div_quo;

   assign sweep_deg = (sweep_deg_ff > SWEEP_MAX) ? SWEEP_MAX : sweep_deg_ff;
   assign sweep     = {sweep_deg, 8'd0};
   assign tau       = (ease_ff == '0) ? DT_W'(1) : ease_ff;
   assign dt_tau    = {1'b0, dt_ff} + {1'b0, tau};

   assign cw         = microcode(pc_ff);
   assign req_tready = cw.op == OP_WAIT_REQ;
   assign accept     = req_tvalid && req_tready;
   assign commit     = cw.op == OP_COMMIT && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      unique case (cw.op)
         OP_WAIT_REQ: adv = req_tvalid;
         OP_DIV_WAIT: adv = !div_busy;
         OP_COMMIT:   adv = !rsp_valid_ff || rsp_tready;
         default:     adv = 1'b1;
      endcase
      pc_in = adv ? cw.nxt : pc_ff;
   end

   // frame time and request fields
   assign elapsed = req_tdata[TIME_W-1:0] - last_time_ff;
   always_comb begin
      if (!seen_ff) begin
         dt_in = DT_FIRST;
      end else if (elapsed > TIME_W'({DT_W{1'b1}})) begin
         dt_in = '1;
      end else begin
         dt_in = elapsed[DT_W-1:0];
      end
      pct_in = (req_tdata[39:33] > PCT_MAX) ? PCT_MAX : req_tdata[39:33];
   end

   // targets, thresholds on the angles from before the tick
   always_comb begin
      logic [ANG_W+3:0] trk_x10, swp_x4;
      logic [ANG_W+2:0] arc_x5;
      trk_x10   = ({4'd0, track_ff} << 3) + ({4'd0, track_ff} << 1);
      swp_x4    = {4'd0, sweep} << 2;
      arc_x5    = ({3'd0, arc_ff} << 2) + {3'd0, arc_ff};
      track_aim = track_ff;
      arc_aim   = arc_ff;
      if (on_ff) begin
         track_aim = sweep;
         if (trk_x10 >= swp_x4) begin
            arc_aim = arc_tgt_ff;
         end
      end else begin
         arc_aim = '0;
         if (arc_x5 <= {3'd0, sweep}) begin
            track_aim = '0;
         end
      end
      d_trk = (track_aim >= track_ff) ? ANG_W'(track_aim - track_ff)
                                      : ANG_W'(track_ff - track_aim);
      d_arc = (arc_aim >= arc_ff) ? ANG_W'(arc_aim - arc_ff) : ANG_W'(arc_ff - arc_aim);
   end

   // operand routing for the shared multiplier and divider
   always_comb begin
      unique case (cw.sel)
         SEL_ARC_TGT: begin
            mul_a = sweep;
            mul_b = DT_W'(pct_ff);
         end
         SEL_CAP: begin
            mul_a = ANG_W'(speed_ff);
            mul_b = dt_ff;
         end
         SEL_TRK: begin
            mul_a = d_trk;
            mul_b = dt_ff;
         end
         default: begin
            mul_a = d_arc;
            mul_b = dt_ff;
         end
      endcase
      div_req.dividend = DVD_W'(prod_ff);
      div_req.divisor  = dt_tau;
      div_req.start    = cw.op == OP_DIV_GO;
   end

   // division by a constant through a reciprocal, quotient in bits 47:31
   always_comb begin
      if (cw.sel == SEL_CAP) begin
         // speed*256*dt/1000 taken as speed*dt*32/125
         scl_a = {prod_ff[SCL_W-6:0], 5'd0};
         scl_m = RCP_CAP;
      end else begin
         scl_a = {1'b0, prod_ff[SCL_W-2:0]};
         scl_m = RCP_PCT;
      end
      scl_prod = {{RCP_W{1'b0}}, scl_a} * {{SCL_W{1'b0}}, scl_m};
      if (cw.sel == SEL_CAP && prod_ff >= CAP_SAT) begin
         scl_q = '1;
      end else begin
         scl_q = scl_prod[RCP_SH+ANG_W-1:RCP_SH];
      end
   end

   cgsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign track_new = move_toward(track_ff, track_aim, stp_trk_ff, cap_ff);
   assign arc_new   = move_toward(arc_ff, arc_aim, stp_arc_ff, cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_ff      <= EASE_RESET;
         speed_ff     <= SPEED_RESET;
         sweep_deg_ff <= SWEEP_RESET;
         pc_ff        <= '0;
         last_time_ff <= '0;
         seen_ff      <= 1'b0;
         track_ff     <= '0;
         arc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_EASE:  ease_ff      <= csr_wdata;
               CSR_SPEED: speed_ff     <= csr_wdata;
               CSR_SWEEP: sweep_deg_ff <= csr_wdata[SWP_W-1:0];
               default:   ;
            endcase
         end
         pc_ff <= pc_in;
         if (accept) begin
            last_time_ff <= req_tdata[TIME_W-1:0];
            seen_ff      <= 1'b1;
         end
         if (commit) begin
            track_ff     <= track_new;
            arc_ff       <= arc_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         dt_ff  <= dt_in;
         on_ff  <= req_tdata[TIME_W];
         pct_ff <= pct_in;
      end
      if (cw.op == OP_MUL) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (cw.op == OP_SCALE) begin
         if (cw.sel == SEL_CAP) begin
            cap_ff <= scl_q;
         end else begin
            arc_tgt_ff <= scl_q;
         end
      end
      if (cw.op == OP_DIV_WAIT && !div_busy) begin
         if (cw.sel == SEL_TRK) begin
            stp_trk_ff <= div_quo;
         end else begin
            stp_arc_ff <= div_quo;
         end
      end
      if (commit) begin
         rsp_data_ff <= {3'd0, arc_new != arc_ff, track_new != track_ff,
                         (track_new != '0) || (arc_new != '0), arc_new, track_new};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the divider is idle whenever a request can be taken
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("divider busy while taking a request");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LAST)
      else $error("step counter out of program");

   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid && rsp_tdata[ANG_W-1:0] == track_ff)
      else $error("committed result not presented");

   a_angle_max: assert property (@(posedge clock) disable iff (reset)
      track_ff <= ANG_MAX && arc_ff <= ANG_MAX)
      else $error("angle beyond full sweep");

endmodule

`default_nettype wire
